>>> design/skt_pkg.sv
// Package for the sorted key table: status codes, operation codes and
// the control bundle that the sequencer sends to the row of cells.
// Depends on nothing.
package skt_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_EDIT   = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  // Status codes of a result beat.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // Control that every cell sees in the same cycle.
  typedef struct packed {
    logic rot;  // rotate the ring by one place
    logic upd;  // move entries for an insert or a re-sort
  } skt_ctl_t;

endpackage

>>> design/skt_if.sv
// Valid/ready channel interfaces for the sorted key table.
// Depends on nothing.
interface skt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] key;
  logic [63:0] new_key;
  logic [31:0] payload;
  logic [7:0]  index;
  modport source (output valid, func, key, new_key, payload, index, input ready);
  modport sink   (input valid, func, key, new_key, payload, index, output ready);
endinterface

interface skt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  position;
  logic [63:0] key_out;
  logic [31:0] payload_out;
  logic [8:0]  entry_count;
  modport source (output valid, status, position, key_out, payload_out, entry_count,
                  input ready);
  modport sink   (input valid, status, position, key_out, payload_out, entry_count,
                  output ready);
endinterface

>>> design/skt_cell.sv
// One cell of the table ring: holds one entry and moves it to or from
// its neighbours. Depends on skt_pkg.
module skt_cell
  import skt_pkg::*;
#(
  parameter int KW  = 64,
  parameter int PW  = 32,
  parameter int CW  = 9,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  skt_ctl_t      ctl,
  input  logic [KW-1:0] cmp_key,
  input  logic [CW-1:0] eq_lim,
  input  logic [CW-1:0] hole,
  input  logic [CW-1:0] fill,
  input  logic [CW-1:0] dest,
  input  logic [KW-1:0] new_key,
  input  logic [PW-1:0] new_pay,
  input  logic [KW-1:0] left_key,
  input  logic [PW-1:0] left_pay,
  input  logic [KW-1:0] right_key,
  input  logic [PW-1:0] right_pay,
  output logic [KW-1:0] key_r,
  output logic [PW-1:0] pay_r,
  output logic          ahead
);

  localparam logic [CW-1:0] ME = CW'(IDX);

  logic [KW-1:0] key_nxt;
  logic [PW-1:0] pay_nxt;
  logic          ord;

  // The entry sorts before the one being placed.
  always_comb begin
    ord   = (key_r < cmp_key) || ((key_r == cmp_key) && (ME < eq_lim));
    ahead = (ME < fill) && (ME != hole) && ord;
  end

  // Rotate the ring, or close the hole and open a slot at the destination in one move.
  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (ctl.rot) begin
      key_nxt = right_key;
      pay_nxt = right_pay;
    end else if (ctl.upd) begin
      if (ME < dest) begin
        if (ME >= hole) begin
          key_nxt = right_key;
          pay_nxt = right_pay;
        end
      end else if (ME == dest) begin
        key_nxt = new_key;
        pay_nxt = new_pay;
      end else if ((ME - CW'(1)) < hole) begin
        key_nxt = left_key;
        pay_nxt = left_pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

endmodule

>>> design/sorted_key_table_unit.sv
// Sorted key table: a ring of DEPTH cells holding entries in ascending key order.
// Depends on skt_pkg, skt_if and skt_cell.
//
// One operation at a time. The ring rotates by one entry a cycle to bring an
// entry to cell 0, and read, the probes of lookup, insert and edit all wait on
// that rotation. Insert and edit move all the entries between the hole and the
// destination at once, in the update state.
// A result waits in an output register; no reset pass is needed.
module sorted_key_table_unit
  import skt_pkg::*;
#(
  parameter int DEPTH        = 256,
  parameter int KEY_BYTES    = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input logic      clk,
  input logic      rst_n,
  skt_in_if.sink   in_if,
  skt_out_if.source out_if
);

  localparam int KW = 8 * KEY_BYTES;
  localparam int PW = (PAYLOAD_BITS > 32) ? 32 : PAYLOAD_BITS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    func_r, func_nxt;
  logic [KW-1:0] k_r, k_nxt, nk_r, nk_nxt;
  logic [PW-1:0] pay_r, pay_nxt;
  logic [AW-1:0] head_r, head_nxt, tgt_r, tgt_nxt;
  logic [CW-1:0] fill_r, fill_nxt, hole_r, hole_nxt, dest_r, dest_nxt;
  logic [SW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid;
  logic [1:0]    rst_st_r, rst_st_nxt;
  logic [CW-1:0] rpos_r, rpos_nxt;
  logic [KW-1:0] rkey_r, rkey_nxt;
  logic [PW-1:0] rpay_r, rpay_nxt;
  logic          ov_r, ov_nxt;
  skt_ctl_t      ctl;

  logic [KW-1:0] ck [DEPTH];
  logic [PW-1:0] cp [DEPTH];
  logic [DEPTH-1:0] bef, dfl;
  logic [CW-1:0] cmp_lim, cell_hole, bound;
  logic [KW-1:0] cmp_key;

  // The ring of cells; cell 0 always shows the entry at head_r.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    skt_cell #(.KW(KW), .PW(PW), .CW(CW), .IDX(i)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cmp_key   (cmp_key),
      .eq_lim    (cmp_lim),
      .hole      (cell_hole),
      .fill      (fill_r),
      .dest      (dest_r),
      .new_key   (cmp_key),
      .new_pay   (pay_r),
      .left_key  (ck[(i + DEPTH - 1) % DEPTH]),
      .left_pay  (cp[(i + DEPTH - 1) % DEPTH]),
      .right_key (ck[(i + 1) % DEPTH]),
      .right_pay (cp[(i + 1) % DEPTH]),
      .key_r     (ck[i]),
      .pay_r     (cp[i]),
      .ahead     (bef[i])
    );
  end

  // Placement inputs: insert keeps equal keys ahead, edit only those before it.
  always_comb begin
    cmp_key   = (func_r == FUNC_INSERT) ? k_r : nk_r;
    cmp_lim   = (func_r == FUNC_INSERT) ? FULL : hole_r;
    cell_hole = hole_r;
  end

  // Count the entries that stay ahead: fill the hole, then find the edge.
  always_comb begin
    bound = '0;
    for (int i = 0; i < DEPTH; i++) begin
      dfl[i] = bef[i] || ((CW'(i) == hole_r) && (i + 1 < DEPTH) && bef[(i + 1) % DEPTH]);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (!dfl[i] && ((i == 0) || dfl[(i + DEPTH - 1) % DEPTH])) begin
        bound = bound | CW'(i);
      end
    end
    if (dfl[DEPTH-1]) begin
      bound = FULL;
    end
  end

  assign mid = SW'((lo_r + hi_r) >> 1);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    k_nxt     = k_r;
    nk_nxt    = nk_r;
    pay_nxt   = pay_r;
    head_nxt  = head_r;
    tgt_nxt   = tgt_r;
    fill_nxt  = fill_r;
    hole_nxt  = hole_r;
    dest_nxt  = dest_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    rst_st_nxt = rst_st_r;
    rpos_nxt  = rpos_r;
    rkey_nxt  = rkey_r;
    rpay_nxt  = rpay_r;
    ov_nxt    = ov_r && !out_if.ready;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          func_nxt   = in_if.func;
          k_nxt      = KW'(in_if.key);
          nk_nxt     = KW'(in_if.new_key);
          pay_nxt    = PW'(in_if.payload);
          lo_nxt     = '0;
          hi_nxt     = SW'(fill_r) - SW'(1);
          tgt_nxt    = '0;
          hole_nxt   = fill_r;
          rst_st_nxt = ST_OK;
          rpos_nxt   = '0;
          rkey_nxt   = '0;
          rpay_nxt   = '0;
          case (in_if.func)
            FUNC_INSERT: begin
              if (fill_r >= FULL) begin
                rst_st_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_ALIGN;
              end
            end
            FUNC_READ: begin
              if ({{CW{1'b0}}, in_if.index} >= {8'd0, fill_r}) begin
                rst_st_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                tgt_nxt   = AW'(in_if.index);
                state_nxt = S_ALIGN;
              end
            end
            default: state_nxt = S_SRCH;
          endcase
        end
      end
      S_ALIGN: begin
        if (head_r == tgt_r) begin
          if (func_r == FUNC_READ) begin
            rpos_nxt  = CW'(tgt_r);
            rkey_nxt  = ck[0];
            rpay_nxt  = cp[0];
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_CALC;
          end
        end else begin
          ctl.rot  = 1'b1;
          head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
        end
      end
      S_SRCH: begin
        if ($signed(lo_r) > $signed(hi_r)) begin
          rst_st_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else if (head_r != AW'(mid)) begin
          ctl.rot  = 1'b1;
          head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
        end else if (k_r < ck[0]) begin
          hi_nxt = mid - SW'(1);
        end else if (k_r > ck[0]) begin
          lo_nxt = mid + SW'(1);
        end else if (func_r == FUNC_LOOKUP) begin
          rpos_nxt  = CW'(mid);
          rkey_nxt  = ck[0];
          rpay_nxt  = cp[0];
          state_nxt = S_DONE;
        end else begin
          hole_nxt  = CW'(mid);
          tgt_nxt   = '0;
          state_nxt = S_ALIGN;
        end
      end
      S_CALC: begin
        dest_nxt  = (hole_r < bound) ? bound - CW'(1) : bound;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        ctl.upd  = 1'b1;
        rpos_nxt = dest_r;
        rkey_nxt = cmp_key;
        rpay_nxt = pay_r;
        if (func_r == FUNC_INSERT) begin
          fill_nxt = fill_r + CW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    k_r      <= k_nxt;
    nk_r     <= nk_nxt;
    pay_r    <= pay_nxt;
    tgt_r    <= tgt_nxt;
    hole_r   <= hole_nxt;
    dest_r   <= dest_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    rst_st_r <= rst_st_nxt;
    rpos_r   <= rpos_nxt;
    rkey_r   <= rkey_nxt;
    rpay_r   <= rpay_nxt;
  end

  // Output beat, held until taken.
  logic [1:0]  os_r;
  logic [7:0]  opos_r;
  logic [63:0] okey_r;
  logic [31:0] opay_r;
  logic [8:0]  ocnt_r;

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!ov_r || out_if.ready)) begin
      os_r   <= rst_st_r;
      opos_r <= 8'(rpos_r);
      okey_r <= 64'(rkey_r);
      opay_r <= 32'(rpay_r);
      ocnt_r <= 9'(fill_r);
    end
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = ov_r;
  assign out_if.status      = os_r;
  assign out_if.position    = opos_r;
  assign out_if.key_out     = okey_r;
  assign out_if.payload_out = opay_r;
  assign out_if.entry_count = ocnt_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL) else $error("fill count beyond table depth");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready) else $error("second beat taken");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status != ST_OK) |-> (out_if.position == 8'd0 &&
     out_if.key_out == 64'd0)) else $error("error result carries data");
`endif

endmodule
